FILE: src/integer_set_table_assert.svh
// Assertion macros used by the checker file of the integer set table.
`ifndef INTEGER_SET_TABLE_ASSERT_SVH
`define INTEGER_SET_TABLE_ASSERT_SVH

// Same-cycle property, gated off during reset.
`define IST_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Antecedent this cycle, consequent on the next edge.
`define IST_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: src/ist_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ist_pkg
// Shared widths, opcodes and status codes of the integer set table.
// ----------------------------------------------------------------------------
package ist_pkg;

  localparam int OPW  = 2;
  localparam int VW   = 32;
  localparam int IW   = 4;
  localparam int STW  = 3;
  localparam int CNTW = 5;

  localparam logic [OPW-1:0] OP_INSERT = 2'd0;
  localparam logic [OPW-1:0] OP_REMOVE = 2'd1;
  localparam logic [OPW-1:0] OP_READ   = 2'd2;

  localparam logic [STW-1:0] ST_INSERTED  = 3'd0;
  localparam logic [STW-1:0] ST_DUPLICATE = 3'd1;
  localparam logic [STW-1:0] ST_FULL      = 3'd2;
  localparam logic [STW-1:0] ST_REMOVED   = 3'd3;
  localparam logic [STW-1:0] ST_NOT_FOUND = 3'd4;
  localparam logic [STW-1:0] ST_READ_OK   = 3'd5;
  localparam logic [STW-1:0] ST_BAD_INDEX = 3'd6;

endpackage

FILE: src/integer_set_table.sv
`timescale 1ns / 1ps
// Sequence: a read passes through S_READ and S_DONE before its result is registered;
//   insert/remove on a non-empty set scans in S_SCAN, a remove shifts in S_SHIFT.
// Flow: one request in flight; the next is taken once the result is registered and
//   the sequencer is idle. The single read port walks the store one entry a cycle.
// Reset: clears the count and control; entries stay undefined, no clearing pass.
// ----------------------------------------------------------------------------
// integer_set_table
// Set of distinct 32-bit integers in insertion order, held in a synchronous memory.
// ----------------------------------------------------------------------------
module integer_set_table #(
  parameter int CAPACITY = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [ist_pkg::OPW-1:0]       opcode,
  input  logic signed [ist_pkg::VW-1:0] value,
  input  logic [ist_pkg::IW-1:0]        index,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [ist_pkg::STW-1:0]       status,
  output logic [ist_pkg::CNTW-1:0]      count,
  output logic signed [ist_pkg::VW-1:0] entry_value
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);

  logic                   mem_wr_en;
  logic [AW-1:0]          mem_wr_addr;
  logic [ist_pkg::VW-1:0] mem_wr_data;
  logic [AW-1:0]          mem_rd_addr;
  logic [ist_pkg::VW-1:0] mem_rd_data;

  ist_ctrl #(
    .CAPACITY(CAPACITY),
    .AW      (AW),
    .CW      (CW)
  ) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .opcode      (opcode),
    .value       (value),
    .index       (index),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .status      (status),
    .count       (count),
    .entry_value (entry_value),
    .mem_wr_en   (mem_wr_en),
    .mem_wr_addr (mem_wr_addr),
    .mem_wr_data (mem_wr_data),
    .mem_rd_addr (mem_rd_addr),
    .mem_rd_data (mem_rd_data)
  );

  ist_mem #(
    .DEPTH(CAPACITY),
    .AW   (AW)
  ) u_mem (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data)
  );

endmodule

FILE: src/ist_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ist_mem
// Entry store: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module ist_mem #(
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  logic                   clk,
  input  logic                   wr_en,
  input  logic [AW-1:0]          wr_addr,
  input  logic [ist_pkg::VW-1:0] wr_data,
  input  logic [AW-1:0]          rd_addr,
  output logic [ist_pkg::VW-1:0] rd_data
);

  logic [ist_pkg::VW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

FILE: src/ist_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ist_ctrl
// Request sequencer: reads an entry by index, scans the store one entry a cycle,
// appends on insert, shifts later entries down on remove, and holds the result register.
// ----------------------------------------------------------------------------
module ist_ctrl #(
  parameter int CAPACITY = 16,
  parameter int AW       = 4,
  parameter int CW       = 5
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [ist_pkg::OPW-1:0]       opcode,
  input  logic signed [ist_pkg::VW-1:0] value,
  input  logic [ist_pkg::IW-1:0]        index,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [ist_pkg::STW-1:0]       status,
  output logic [ist_pkg::CNTW-1:0]      count,
  output logic signed [ist_pkg::VW-1:0] entry_value,
  output logic                          mem_wr_en,
  output logic [AW-1:0]                 mem_wr_addr,
  output logic [ist_pkg::VW-1:0]        mem_wr_data,
  output logic [AW-1:0]                 mem_rd_addr,
  input  logic [ist_pkg::VW-1:0]        mem_rd_data
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SCAN  = 3'd1;
  localparam logic [2:0] S_SHIFT = 3'd2;
  localparam logic [2:0] S_READ  = 3'd3;
  localparam logic [2:0] S_DONE  = 3'd4;

  logic [2:0]                   state, state_next;
  logic                         op_remove, op_remove_next;
  logic [ist_pkg::VW-1:0]       key, key_next;
  logic [AW-1:0]                ptr, ptr_next;
  logic [CW-1:0]                cnt, cnt_next;
  logic [ist_pkg::STW-1:0]      res_status, res_status_next;
  logic [ist_pkg::VW-1:0]       res_value, res_value_next;
  logic [AW+ist_pkg::IW-1:0]    idx_addr_w;
  logic [CW+ist_pkg::IW-1:0]    idx_cmp_w;
  logic [CW+ist_pkg::CNTW-1:0]  cnt_out_w;
  logic                         rd_ok;
  logic                         last;
  logic                         shift_last;
  logic                         out_free;

  assign idx_addr_w = (AW + ist_pkg::IW)'(index);
  assign idx_cmp_w  = (CW + ist_pkg::IW)'(index);
  assign rd_ok      = idx_cmp_w < (CW + ist_pkg::IW)'(cnt);
  assign last       = (CW'(ptr) == cnt - CW'(1));
  assign shift_last = (CW'(ptr) + CW'(1) == cnt - CW'(1));
  assign out_free   = !out_valid || !out_stall;
  assign in_stall   = (state != S_IDLE);

  always_comb begin
    state_next      = state;
    op_remove_next  = op_remove;
    key_next        = key;
    ptr_next        = ptr;
    cnt_next        = cnt;
    res_status_next = res_status;
    res_value_next  = res_value;
    mem_wr_en       = 1'b0;
    mem_wr_addr     = cnt[AW-1:0];
    mem_wr_data     = key;
    mem_rd_addr     = ptr + AW'(1);

    unique case (state)
      S_IDLE: begin
        mem_rd_addr = '0;
        if (in_valid) begin
          key_next       = value;
          op_remove_next = (opcode == ist_pkg::OP_REMOVE);
          ptr_next       = '0;
          res_value_next = '0;
          if (opcode == ist_pkg::OP_INSERT) begin
            if (cnt == '0) begin
              // empty store: nothing to scan, append at slot zero
              mem_wr_en       = 1'b1;
              mem_wr_addr     = '0;
              mem_wr_data     = value;
              cnt_next        = CW'(1);
              res_status_next = ist_pkg::ST_INSERTED;
              state_next      = S_DONE;
            end else begin
              state_next = S_SCAN;
            end
          end else if (opcode == ist_pkg::OP_REMOVE) begin
            if (cnt == '0) begin
              res_status_next = ist_pkg::ST_NOT_FOUND;
              state_next      = S_DONE;
            end else begin
              state_next = S_SCAN;
            end
          end else begin
            mem_rd_addr     = idx_addr_w[AW-1:0];
            res_status_next = rd_ok ? ist_pkg::ST_READ_OK : ist_pkg::ST_BAD_INDEX;
            state_next      = S_READ;
          end
        end
      end

      S_READ: begin
        res_value_next = (res_status == ist_pkg::ST_READ_OK) ? mem_rd_data : '0;
        state_next     = S_DONE;
      end

      S_SCAN: begin
        // mem_rd_data holds entry ptr; entry ptr+1 is being fetched
        if (mem_rd_data == key) begin
          if (!op_remove) begin
            res_status_next = ist_pkg::ST_DUPLICATE;
            state_next      = S_DONE;
          end else if (last) begin
            cnt_next        = cnt - CW'(1);
            res_status_next = ist_pkg::ST_REMOVED;
            state_next      = S_DONE;
          end else begin
            state_next = S_SHIFT;
          end
        end else if (last) begin
          if (op_remove) begin
            res_status_next = ist_pkg::ST_NOT_FOUND;
          end else if (cnt >= CW'(CAPACITY)) begin
            res_status_next = ist_pkg::ST_FULL;
          end else begin
            mem_wr_en       = 1'b1;
            cnt_next        = cnt + CW'(1);
            res_status_next = ist_pkg::ST_INSERTED;
          end
          state_next = S_DONE;
        end else begin
          ptr_next = ptr + AW'(1);
        end
      end

      S_SHIFT: begin
        // entry ptr+1 arrives now; move it down and prefetch ptr+2
        mem_rd_addr = ptr + AW'(2);
        mem_wr_en   = 1'b1;
        mem_wr_addr = ptr;
        mem_wr_data = mem_rd_data;
        if (shift_last) begin
          cnt_next        = cnt - CW'(1);
          res_status_next = ist_pkg::ST_REMOVED;
          state_next      = S_DONE;
        end else begin
          ptr_next = ptr + AW'(1);
        end
      end

      S_DONE: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    op_remove  <= op_remove_next;
    key        <= key_next;
    ptr        <= ptr_next;
    res_status <= res_status_next;
    res_value  <= res_value_next;
  end

  assign cnt_out_w = (CW + ist_pkg::CNTW)'(cnt);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_DONE && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && out_free) begin
      status      <= res_status;
      count       <= cnt_out_w[ist_pkg::CNTW-1:0];
      entry_value <= res_value;
    end
  end

endmodule

FILE: src/ist_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ist_checker
// Port-level checks of the integer set table, bound to the top level.
// ----------------------------------------------------------------------------
`include "integer_set_table_assert.svh"

module ist_checker #(
  parameter int CAPACITY = 16
) (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_valid,
  input logic                          in_stall,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic [ist_pkg::STW-1:0]       status,
  input logic [ist_pkg::CNTW-1:0]      count,
  input logic signed [ist_pkg::VW-1:0] entry_value
);

  localparam int CMPW = ist_pkg::CNTW + 9;

  logic [CMPW-1:0] count_w;
  logic            busy_unused;

  assign count_w     = CMPW'(count);
  assign busy_unused = in_valid & in_stall;

  `IST_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && out_stall, out_valid && $stable(status) && $stable(count) && $stable(entry_value), "stalled result changed")
  `IST_ASSERT(a_value_only_on_read, clk, rst, !out_valid || status == ist_pkg::ST_READ_OK || entry_value == '0, "entry value set on a non-read result")
  `IST_ASSERT(a_status_code, clk, rst, !out_valid || status <= ist_pkg::ST_BAD_INDEX, "status code out of range")
  `IST_ASSERT(a_count_bound, clk, rst, !out_valid || CAPACITY >= 32 || count_w <= CMPW'(CAPACITY), "count above capacity")
  `IST_ASSERT(a_insert_nonempty, clk, rst, !out_valid || status != ist_pkg::ST_INSERTED || count != '0 || CAPACITY >= 32 || busy_unused, "insert reported with empty set")

endmodule

bind integer_set_table ist_checker #(.CAPACITY(CAPACITY)) u_ist_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_valid),
  .in_stall    (in_stall),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .status      (status),
  .count       (count),
  .entry_value (entry_value)
);
